// ===== hdl/wnm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the wildcard name matcher: sizes, pattern codes, register
// indexes, shared types and the star-closure function. No dependencies.
package wnm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int POS_W       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PAT_W       = 2 * CFG_DATA_W;
  localparam int CLOSE_LVLS  = $clog2(POS_W);

  localparam logic [CHAR_W-1:0] STAR_CHAR     = 8'h2A;
  localparam logic [CHAR_W-1:0] QUESTION_CHAR = 8'h3F;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_idx_e;

  typedef logic [POS_W-1:0] pos_t;

  // Pattern setup as seen by the datapath.
  typedef struct packed {
    logic [PAT_W-1:0] pat_chars;
    logic [LEN_W-1:0] pat_len;
  } cfg_t;

  // One name byte with its framing marks.
  typedef struct packed {
    logic [CHAR_W-1:0] name_char;
    logic              first_of_name;
    logic              last_of_name;
  } item_t;

  // Follow runs of '*' positions without consuming a byte. Position j is
  // reached if some active position k <= j is followed by stars at k..j-1.
  // This is a carry chain, solved here as a log-depth prefix network.
  function automatic pos_t star_closure(pos_t v, logic [MAX_PATTERN-1:0] star);
    pos_t g;
    pos_t p;
    g = v;
    p = {star, 1'b0};
    for (int k = 0; k < CLOSE_LVLS; k++) begin
      g = g | (p & (g << (1 << k)));
      p = p & (p << (1 << k));
    end
    return g;
  endfunction

endpackage

// ===== hdl/wnm_if.sv =====
`timescale 1ns / 1ps
// Stream interfaces for the name matcher: the name byte channel and the
// match result channel. Depends on wnm_pkg for field widths.
interface wnm_in_if;
  logic                          valid;
  logic                          ready;
  logic [wnm_pkg::CHAR_W-1:0]    name_char;
  logic                          first_of_name;
  logic                          last_of_name;

  modport source (output valid, output name_char, output first_of_name,
                  output last_of_name, input ready);
  modport sink   (input valid, input name_char, input first_of_name,
                  input last_of_name, output ready);
endinterface

interface wnm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// ===== hdl/wnm_cfg_regs.sv =====
`timescale 1ns / 1ps
// Pattern configuration registers of the name matcher with write decode.
// Depends on wnm_pkg.
module wnm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wnm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output wnm_pkg::cfg_t                    cfg_o
);
  import wnm_pkg::*;

  logic [CFG_DATA_W-1:0] pat_low_q, pat_low_d;
  logic [CFG_DATA_W-1:0] pat_high_q, pat_high_d;
  logic [LEN_W-1:0]      pat_len_q, pat_len_d;
  logic [LEN_W-1:0]      wr_len;

  // Low LEN_W bits only; lengths over MAX_PATTERN are held at the maximum.
  assign wr_len = (cfg_data_i[LEN_W-1:0] > LEN_W'(MAX_PATTERN)) ?
                  LEN_W'(MAX_PATTERN) : cfg_data_i[LEN_W-1:0];

  // Write decode; an index past the list is ignored.
  always_comb begin
    pat_low_d  = pat_low_q;
    pat_high_d = pat_high_q;
    pat_len_d  = pat_len_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LOW:  pat_low_d  = cfg_data_i;
        CFG_PAT_HIGH: pat_high_d = cfg_data_i;
        CFG_PAT_LEN:  pat_len_d  = wr_len;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else begin
      pat_low_q  <= pat_low_d;
      pat_high_q <= pat_high_d;
      pat_len_q  <= pat_len_d;
    end
  end

  assign cfg_o.pat_chars = {pat_high_q, pat_low_q};
  assign cfg_o.pat_len   = pat_len_q;

endmodule

// ===== hdl/wnm_step.sv =====
`timescale 1ns / 1ps
// One automaton step of the glob matcher: advances the active-position
// vector by one name byte and derives the match flag. Depends on wnm_pkg.
module wnm_step (
  input  wnm_pkg::cfg_t   cfg_i,
  input  wnm_pkg::item_t  item_i,
  input  wnm_pkg::pos_t   state_i,
  output wnm_pkg::pos_t   next_o,
  output logic            matched_o
);
  import wnm_pkg::*;

  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] single;
  pos_t                   mask;
  pos_t                   start;
  pos_t                   cur;
  pos_t                   advanced;
  pos_t                   next;

  // Per-position pattern classes; positions past the length do nothing.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      logic [CHAR_W-1:0] p;
      logic              used;
      p         = cfg_i.pat_chars[i*CHAR_W +: CHAR_W];
      used      = LEN_W'(i) < cfg_i.pat_len;
      star[i]   = used && (p == STAR_CHAR);
      single[i] = used && (p != STAR_CHAR) &&
                  ((p == QUESTION_CHAR) || (p == item_i.name_char));
    end
    for (int j = 0; j < POS_W; j++) begin
      mask[j] = LEN_W'(j) <= cfg_i.pat_len;
    end
  end

  // A new name restarts from position zero and its star closure.
  assign start = star_closure(POS_W'(1), star);
  assign cur   = item_i.first_of_name ? start : (state_i & mask);

  // A star keeps its position; a literal or '?' hit moves one ahead.
  always_comb begin
    advanced = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cur[i] && star[i]) advanced[i] = 1'b1;
      if (cur[i] && single[i]) advanced[i+1] = 1'b1;
    end
  end

  assign next      = star_closure(advanced, star) & mask;
  assign next_o    = next;
  assign matched_o = (cfg_i.pat_len != '0) && next[cfg_i.pat_len];

endmodule

// ===== hdl/wildcard_name_matcher_core.sv =====
`timescale 1ns / 1ps
// Top level of the wildcard name matcher: input register, step logic and
// result register. Depends on wnm_pkg, wnm_if, wnm_cfg_regs and wnm_step.
//
// Usage:
//   Name bytes arrive on in_i, one per beat, with first_of_name on the first
//   byte of a name and last_of_name on its final byte. The beat with
//   last_of_name yields one beat on out_o carrying matched; other beats
//   yield nothing. The pattern ('*' any run, '?' any one byte) and its
//   length are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   no name is in flight.
//   Throughput is one byte per cycle unless a last byte waits on out_o;
//   the position vector update is a short prefix network between the input
//   register and the state register. A last byte is held in the input
//   register, then its match flag is captured in the result register.
//   Reset clears the pattern, its length and the position vector, and
//   empties both registers. When out_o stalls, the result register holds;
//   bytes that produce no result keep flowing, and a last byte waits in the
//   input register until the result register frees up.
module wildcard_name_matcher_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wnm_in_if.sink                           in_i,
  wnm_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wnm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import wnm_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid_q;
  pos_t  state_q;
  pos_t  next;
  logic  matched;
  logic  out_valid_q, out_valid_d;
  logic  out_matched_q;
  logic  item_fire;

  wnm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wnm_step u_step (
    .cfg_i     (cfg),
    .item_i    (item_q),
    .state_i   (state_q),
    .next_o    (next),
    .matched_o (matched)
  );

  // The held byte moves on unless it carries a result with nowhere to go.
  assign item_fire  = item_valid_q &&
                      (!item_q.last_of_name || !out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || item_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.name_char     <= in_i.name_char;
      item_q.first_of_name <= in_i.first_of_name;
      item_q.last_of_name  <= in_i.last_of_name;
    end
  end

  // Active-position vector advances once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (item_fire) begin
      state_q <= next;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_fire && item_q.last_of_name) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire && item_q.last_of_name) begin
      out_matched_q <= matched;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_matched_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_name_matcher_core: directed and random
// name streams against a glob predictor. Depends on wnm_pkg, wnm_if and the RTL.
module tb_top;
  import wnm_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int LOADS_PER_MODE = 6;
  localparam int MAX_GAP      = 12;

  localparam logic [CHAR_W-1:0] SYM_A = 8'h61;
  localparam logic [CHAR_W-1:0] SYM_B = 8'h62;

  typedef logic [PAT_W-1:0] glob_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  wnm_in_if  u_in ();
  wnm_out_if u_out ();

  wildcard_name_matcher_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (u_in),
    .out_o       (u_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Mirror of the pattern setup and of the live position vector.
  glob_word_t       glob_chars     = '0;
  logic [LEN_W-1:0] glob_len       = '0;
  pos_t             live_positions = '0;
  logic             expected_matches [$];

  int error_count    = 0;
  int items_sent     = 0;
  int names_checked  = 0;
  int names_matched  = 0;
  int pattern_loads  = 0;
  int cycle_count    = 0;
  int sender_idle_pct = 23;
  int recv_idle_pct   = 55;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the current idle rate.
  initial begin
    u_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      u_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               expected_matches.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int glob_eff_len();
    return (int'(glob_len) > MAX_PATTERN) ? MAX_PATTERN : int'(glob_len);
  endfunction

  function automatic logic [CHAR_W-1:0] glob_byte(int i);
    return glob_chars[i*CHAR_W +: CHAR_W];
  endfunction

  // Propagate active positions across '*' without consuming a byte.
  function automatic pos_t spread_over_stars(pos_t v, int len);
    pos_t r;
    r = v;
    for (int i = 0; i < len; i++) begin
      if (r[i] && glob_byte(i) == STAR_CHAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  // Next position vector after consuming one name byte.
  function automatic pos_t advance_positions(logic [CHAR_W-1:0] c, logic first);
    int   len;
    pos_t mask;
    pos_t cur;
    pos_t nxt;
    len  = glob_eff_len();
    mask = pos_t'((32'd1 << (len + 1)) - 32'd1);
    cur  = first ? spread_over_stars(pos_t'(1), len) : (live_positions & mask);
    nxt  = '0;
    for (int i = 0; i < len; i++) begin
      if (cur[i]) begin
        if (glob_byte(i) == STAR_CHAR) nxt[i] = 1'b1;
        else if (glob_byte(i) == QUESTION_CHAR || glob_byte(i) == c) nxt[i+1] = 1'b1;
      end
    end
    return spread_over_stars(nxt, len) & mask;
  endfunction

  // Predict on accepted name beats, check on accepted result beats.
  always @(posedge clk_i) begin : match_monitor
    pos_t nxt;
    int   len;
    logic want;
    if (rst_ni) begin
      if (u_in.valid && u_in.ready) begin
        len = glob_eff_len();
        nxt = advance_positions(u_in.name_char, u_in.first_of_name);
        live_positions = nxt;
        if (u_in.last_of_name) expected_matches.push_back(len > 0 && nxt[len]);
      end
      if (u_out.valid && u_out.ready) begin
        if (expected_matches.size() == 0) begin
          error_count++;
          $display("%0t: result beat with no name pending, actual matched=%0b",
                   $time, u_out.matched);
        end else begin
          want = expected_matches.pop_front();
          names_checked++;
          if (want) names_matched++;
          if (u_out.matched !== want) begin
            error_count++;
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $time, want, u_out.matched);
          end
        end
      end
    end
  end

  function automatic logic [CHAR_W-1:0] pick_name_sym();
    int r;
    r = $urandom_range(99);
    if (r < 40) return SYM_A;
    if (r < 75) return SYM_B;
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_glob_sym();
    int r;
    r = $urandom_range(99);
    if (r < 25) return SYM_A;
    if (r < 45) return SYM_B;
    if (r < 65) return STAR_CHAR;
    if (r < 80) return QUESTION_CHAR;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Pattern bytes from text; bytes past the text are random filler.
  function automatic glob_word_t glob_from_text(string s);
    glob_word_t w;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i*CHAR_W +: CHAR_W] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(255));
    end
    return w;
  endfunction

  // Send one name beat after a random gap; valid stays high on return.
  task automatic send_item(logic [CHAR_W-1:0] c, logic first, logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      u_in.valid         <= 1'b0;
      u_in.name_char     <= CHAR_W'($urandom_range(255));
      u_in.first_of_name <= 1'($urandom_range(1));
      u_in.last_of_name  <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk_i);
    end
    u_in.valid         <= 1'b1;
    u_in.name_char     <= c;
    u_in.first_of_name <= first;
    u_in.last_of_name  <= last;
    do @(posedge clk_i); while (!u_in.ready);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], k == 0, k == s.len() - 1);
  endtask

  // Hold off the sender until every pending result has come back and the
  // pipeline has flushed any beats that carry no result.
  task automatic wait_idle();
    u_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_pattern(glob_word_t w, int len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PAT_LOW;
    cfg_data_i  <= w[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_index_i <= CFG_PAT_HIGH;
    cfg_data_i  <= w[PAT_W-1:CFG_DATA_W];
    @(posedge clk_i);
    cfg_index_i <= CFG_PAT_LEN;
    cfg_data_i  <= CFG_DATA_W'(len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    glob_chars  = w;
    glob_len    = LEN_W'(len);
    pattern_loads++;
  endtask

  // Empty pattern after reset and after a write: nothing matches.
  task automatic test_empty_pattern();
    send_item(SYM_A, 1'b0, 1'b1);
    send_item(SYM_A, 1'b1, 1'b1);
    load_pattern(glob_from_text("****"), 0);
    send_item(SYM_A, 1'b1, 1'b1);
  endtask

  // Star and question mark, including a question mark right after a star.
  task automatic test_wildcards();
    load_pattern(glob_from_text("a?c*"), 4);
    send_text("abc");
    send_text("axcde");
    send_text("ab");
    load_pattern(glob_from_text("*?b"), 3);
    send_text("xb");
    send_text("b");
  endtask

  // Zero and all-ones bytes in the pattern are plain literals.
  task automatic test_special_bytes();
    glob_word_t w;
    w = '0;
    w[2*CHAR_W-1:CHAR_W] = 8'hFF;
    load_pattern(w, 2);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  // A name without a first mark continues from the stored vector; a beat
  // with both marks is a one-byte name.
  task automatic test_framing();
    load_pattern(glob_from_text("ab*"), 3);
    send_text("ab");
    send_item(8'h63, 1'b0, 1'b1);
    send_item(8'h7A, 1'b1, 1'b1);
  endtask

  // A length above the maximum is clamped to the full pattern.
  task automatic test_long_length();
    load_pattern({8'h7A, {15{STAR_CHAR}}}, 31);
    send_item(8'h7A, 1'b1, 1'b1);
    send_item(8'h71, 1'b1, 1'b1);
  endtask

  // One random name, mostly shaped after the pattern so that matches are
  // common, with some broken framing mixed in.
  task automatic send_random_name();
    logic [CHAR_W-1:0] name [$];
    logic [CHAR_W-1:0] pc;
    int  len;
    int  framing;
    int  last_idx;
    logic f;
    logic l;
    len = glob_eff_len();
    if ($urandom_range(99) < 70) begin
      for (int i = 0; i < len; i++) begin
        pc = glob_byte(i);
        if (pc == STAR_CHAR) begin
          repeat ($urandom_range(3)) name.push_back(pick_name_sym());
        end else if (pc == QUESTION_CHAR) begin
          name.push_back(pick_name_sym());
        end else begin
          name.push_back(pc);
        end
      end
      if (name.size() > 0 && $urandom_range(99) < 25)
        name[$urandom_range(name.size() - 1)] = pick_name_sym();
    end else begin
      repeat ($urandom_range(1, 10)) name.push_back(pick_name_sym());
    end
    if (name.size() == 0) name.push_back(pick_name_sym());
    framing  = $urandom_range(99);
    last_idx = name.size() - 1;
    for (int k = 0; k <= last_idx; k++) begin
      f = (k == 0);
      l = (k == last_idx);
      if (framing >= 94) begin
        f = 1'($urandom_range(1));
        l = 1'($urandom_range(1));
      end else if (framing >= 88) begin
        l = 1'b0;
      end else if (framing >= 80) begin
        f = 1'b0;
      end
      send_item(name[k], f, l);
    end
  endtask

  // Random names over several patterns, extremes of the length included.
  task automatic test_random_names(int send_pct, int recv_pct, int budget);
    glob_word_t w;
    int len;
    int clamped;
    int target;
    sender_idle_pct = send_pct;
    recv_idle_pct   = recv_pct;
    for (int p = 0; p < LOADS_PER_MODE; p++) begin
      case (p)
        0: len = MAX_PATTERN;
        1: len = 0;
        2: len = $urandom_range(MAX_PATTERN + 1, 31);
        default: len = $urandom_range(1, MAX_PATTERN);
      endcase
      clamped = (len > MAX_PATTERN) ? MAX_PATTERN : len;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        w[i*CHAR_W +: CHAR_W] = (i < clamped) ? pick_glob_sym()
                                              : CHAR_W'($urandom_range(255));
      end
      load_pattern(w, len);
      target = items_sent + budget / LOADS_PER_MODE;
      while (items_sent < target) send_random_name();
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CFG_PAT_LOW;
    cfg_data_i         <= '0;
    u_in.valid         <= 1'b0;
    u_in.name_char     <= '0;
    u_in.first_of_name <= 1'b0;
    u_in.last_of_name  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pattern();
    test_wildcards();
    test_special_bytes();
    test_framing();
    test_long_length();
    test_random_names(23, 55, RANDOM_ITEMS / 3);
    test_random_names(55, 23, RANDOM_ITEMS / 3);
    test_random_names(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_idle();

    $display("Sent %0d name bytes over %0d pattern loads; %0d names checked, %0d matched.",
             items_sent, pattern_loads, names_checked, names_matched);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
